### rtl/gif_frame_pixel_compositor_assert.svh
// Assertion macros for the GIF frame pixel compositor.
`ifndef GIF_FRAME_PIXEL_COMPOSITOR_ASSERT_SVH
`define GIF_FRAME_PIXEL_COMPOSITOR_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GFPC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GFPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GFPC_ASSERT(lbl, ante, cons, msg)
`define GFPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/gfpc_pkg.sv
// Shared types, register codes and interlace tables of the GIF frame pixel compositor.
`default_nettype none

package gfpc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FRAME_LEFT    = 3'd0,
    CFG_FRAME_TOP     = 3'd1,
    CFG_FRAME_WIDTH   = 3'd2,
    CFG_FRAME_HEIGHT  = 3'd3,
    CFG_CANVAS_WIDTH  = 3'd4,
    CFG_INTERLACED    = 3'd5,
    CFG_FRAME_TRANSP  = 3'd6,
    CFG_GLOBAL_TRANSP = 3'd7
  } cfg_reg_e;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned AddrW     = 24;
  localparam int unsigned NumPass   = 4;

  // Transparent index value that never matches a colour index
  localparam logic [8:0] NoTransparent = 9'd256;

  typedef logic [23:0] rgb_t;

  // First frame row of each interlace pass
  function automatic logic [3:0] pass_start(input logic [1:0] pass);
    logic [3:0] v;
    unique case (pass)
      2'd0: v = 4'd0;
      2'd1: v = 4'd4;
      2'd2: v = 4'd2;
      2'd3: v = 4'd1;
    endcase
    return v;
  endfunction

  // Row step of each interlace pass
  function automatic logic [3:0] pass_step(input logic [1:0] pass);
    logic [3:0] v;
    unique case (pass)
      2'd0: v = 4'd8;
      2'd1: v = 4'd8;
      2'd2: v = 4'd4;
      2'd3: v = 4'd2;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/gif_frame_pixel_compositor.sv
// Pixels pass stage 1, then the output register. While in_stall_o is low, one
// request per cycle is taken, palette loads and pixels alike; the palette RAM
// has one write and one read port, and a load and a pixel never share a cycle.
// Reset clears the frame registers to their defaults and the counters to zero;
// palette contents stay undefined until loaded, no clearing pass is run.
`default_nettype none

`include "gif_frame_pixel_compositor_assert.svh"

module gif_frame_pixel_compositor #(
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [gfpc_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  wire logic [gfpc_pkg::CfgDataW-1:0]   cfg_data_i,
  // input request channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            op_i,
  input  wire logic [7:0]                      index_i,
  input  wire logic [7:0]                      red_in_i,
  input  wire logic [7:0]                      green_in_i,
  input  wire logic [7:0]                      blue_in_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 write_enable_o,
  output logic [gfpc_pkg::AddrW-1:0]           canvas_address_o,
  output logic [7:0]                           red_out_o,
  output logic [7:0]                           green_out_o,
  output logic [7:0]                           blue_out_o,
  output logic                                 frame_done_o
);

  import gfpc_pkg::*;

  localparam int unsigned PalAw = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(MAX_DIMENSION);
  localparam int unsigned BndW  = (CntW + 1 > 13) ? CntW + 1 : 13;
  localparam int unsigned RowW  = ((CntW > 12) ? CntW : 12) + 1;
  localparam int unsigned ProdW = RowW + 13;
  localparam logic [8:0]  DepthLim = 9'(PALETTE_DEPTH);
  localparam logic [BndW-1:0] MaxDim = BndW'(MAX_DIMENSION);

  // configuration registers
  logic [11:0] frame_left_q, frame_top_q;
  logic [12:0] frame_width_q, frame_height_q, canvas_width_q;
  logic        interlaced_q;
  logic [8:0]  frame_transp_q, global_transp_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_left_q    <= '0;
      frame_top_q     <= '0;
      frame_width_q   <= 13'd1;
      frame_height_q  <= 13'd1;
      canvas_width_q  <= 13'd1;
      interlaced_q    <= 1'b0;
      frame_transp_q  <= NoTransparent;
      global_transp_q <= NoTransparent;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_FRAME_LEFT:    frame_left_q    <= cfg_data_i[11:0];
        CFG_FRAME_TOP:     frame_top_q     <= cfg_data_i[11:0];
        CFG_FRAME_WIDTH:   frame_width_q   <= cfg_data_i;
        CFG_FRAME_HEIGHT:  frame_height_q  <= cfg_data_i;
        CFG_CANVAS_WIDTH:  canvas_width_q  <= cfg_data_i;
        CFG_INTERLACED:    interlaced_q    <= cfg_data_i[0];
        CFG_FRAME_TRANSP:  frame_transp_q  <= cfg_data_i[8:0];
        CFG_GLOBAL_TRANSP: global_transp_q <= cfg_data_i[8:0];
      endcase
    end
  end

  // pipeline handshake
  logic s1_valid_q, out_valid_q;
  logic adv, in_acc, pix_acc;

  assign adv        = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pix_acc    = in_acc && op_i;

  // effective frame bounds: zero acts as one, clamp at the maximum
  logic [BndW-1:0] w_eff, h_eff;

  always_comb begin
    w_eff = BndW'(frame_width_q);
    h_eff = BndW'(frame_height_q);
    if (w_eff == '0) w_eff = BndW'(1);
    else if (w_eff > MaxDim) w_eff = MaxDim;
    if (h_eff == '0) h_eff = BndW'(1);
    else if (h_eff > MaxDim) h_eff = MaxDim;
  end

  // raster counters
  logic [CntW-1:0] col_q, col_d, row_q, row_d;
  logic [1:0]      pass_q, pass_d;
  logic            done_d;

  always_comb begin
    logic [BndW-1:0] col_inc, row_inc;
    logic [2:0]      cand;
    logic            found;
    col_inc = BndW'(col_q) + BndW'(1);
    row_inc = '0;
    cand    = '0;
    found   = 1'b0;
    col_d   = col_q;
    row_d   = row_q;
    pass_d  = pass_q;
    done_d  = 1'b0;
    if (col_inc < w_eff) begin
      col_d = CntW'(col_inc);
    end else begin
      col_d = '0;
      if (!interlaced_q) begin
        row_inc = BndW'(row_q) + BndW'(1);
        if (row_inc < h_eff) begin
          row_d = CntW'(row_inc);
        end else begin
          row_d  = '0;
          pass_d = '0;
          done_d = 1'b1;
        end
      end else begin
        row_inc = BndW'(row_q) + BndW'(pass_step(pass_q));
        if (row_inc < h_eff) begin
          row_d = CntW'(row_inc);
        end else begin
          // skip to the next pass whose first row lies inside the frame
          for (int k = 1; k < NumPass; k++) begin
            cand = 3'(pass_q) + 3'(k);
            if (!found && cand < 3'(NumPass) &&
                BndW'(pass_start(cand[1:0])) < h_eff) begin
              found  = 1'b1;
              pass_d = cand[1:0];
              row_d  = CntW'(pass_start(cand[1:0]));
            end
          end
          if (!found) begin
            pass_d = '0;
            row_d  = '0;
            done_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pass_q <= '0;
    end else if (pix_acc) begin
      col_q  <= col_d;
      row_q  <= row_d;
      pass_q <= pass_d;
    end
  end

  // palette RAM: one write port, one registered read port
  rgb_t pal_mem [PALETTE_DEPTH];
  rgb_t pal_rd_q;
  logic pal_we;

  assign pal_we = in_acc && !op_i && ({1'b0, index_i} < DepthLim);

  always_ff @(posedge clk_i) begin
    if (pal_we) pal_mem[index_i[PalAw-1:0]] <= {red_in_i, green_in_i, blue_in_i};
    if (pix_acc) pal_rd_q <= pal_mem[index_i[PalAw-1:0]];
  end

  // stage 1: transparency, address product, frame end flag
  logic             s1_opaque_q, s1_inrange_q, s1_done_q;
  logic [ProdW-1:0] s1_prod_q;
  logic [RowW-1:0]  s1_offs_q;
  logic [RowW-1:0]  top_row;

  assign top_row = RowW'(frame_top_q) + RowW'(row_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc || adv) begin
      s1_valid_q <= pix_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_opaque_q  <= !(({1'b0, index_i} == frame_transp_q) ||
                        ({1'b0, index_i} == global_transp_q));
      s1_inrange_q <= ({1'b0, index_i} < DepthLim);
      s1_done_q    <= done_d;
      s1_prod_q    <= ProdW'(top_row) * ProdW'(canvas_width_q);
      s1_offs_q    <= RowW'(frame_left_q) + RowW'(col_q);
    end
  end

  // output register
  logic [ProdW-1:0] addr_sum;
  rgb_t             color;

  assign addr_sum = s1_prod_q + ProdW'(s1_offs_q);
  assign color    = (s1_opaque_q && s1_inrange_q) ? pal_rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!(out_valid_q && out_stall_i)) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      write_enable_o   <= s1_opaque_q;
      canvas_address_o <= addr_sum[AddrW-1:0];
      red_out_o        <= color[23:16];
      green_out_o      <= color[15:8];
      blue_out_o       <= color[7:0];
      frame_done_o     <= s1_done_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  `GFPC_ASSERT_NEXT(a_load_no_result, in_acc && !op_i, !s1_valid_q, "palette load made a result")
  `GFPC_ASSERT_NEXT(a_s1_hold, s1_valid_q && !adv, s1_valid_q, "stage 1 dropped a pixel")
  `GFPC_ASSERT(a_skip_black, out_valid_o && !write_enable_o, {red_out_o, green_out_o, blue_out_o} == '0, "skip with colour")

endmodule

`default_nettype wire
